### sv/grs7p_pkg.sv
// shared types, constants and helpers for the 3d seven-point restriction block
package grs7p_pkg;

    localparam int MAX_INTERIOR_DEF = 63;
    localparam int SAMPLE_WIDTH_DEF = 32;
    localparam int COORD_W          = 6;
    localparam int CFG_IDX_W        = 1;
    localparam int CFG_DATA_W       = 32;
    localparam int N_W              = 6;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FINE_INTERIOR  = 1'b0,
        REG_BOUNDARY_VALUE = 1'b1
    } t_cfg_reg;

    typedef struct packed {
        logic               bnd;
        logic               stc;
        logic               lst;
        logic [COORD_W-1:0] cx;
        logic [COORD_W-1:0] cy;
        logic [COORD_W-1:0] cz;
    } t_ctl;

endpackage

### sv/grid_restrict_3d_7point_core.sv
// top level of the 3d seven-point multigrid restriction block
//
// channel  | dir | fields (low bit first)
// s_axis   | in  | tdata: sample
// m_axis   | out | tdata: coarse_x, coarse_y, coarse_z, coarse_value; tuser: on_boundary; tlast
// cfg      | in  | 0 fine_interior, 1 boundary_value
//
// one fine sample per cycle unless the output stalls
// pipeline: classify and address, plane store read, quotients by twelve, final sum
// the whole pipe advances whenever the output register is free or taken
// a stall holds every stage; nothing is dropped or repeated
// synchronous active-low reset clears position and valid bits and resets the two config registers
module grid_restrict_3d_7point_core #(
    parameter int MAX_INTERIOR = grs7p_pkg::MAX_INTERIOR_DEF,
    parameter int SAMPLE_WIDTH = grs7p_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [SAMPLE_WIDTH-1:0]           s_axis_tdata,   // sample
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // coarse_x, coarse_y, coarse_z, coarse_value, zero fill
    output logic [((18+SAMPLE_WIDTH+7)/8)*8-1:0] m_axis_tdata,
    output logic                              m_axis_tuser,   // on_boundary
    output logic                              m_axis_tlast,
    input  logic                              i_cfg_we,
    input  logic [grs7p_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [grs7p_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    localparam int OW = ((18 + SAMPLE_WIDTH + 7) / 8) * 8;

    logic [grs7p_pkg::N_W-1:0] r_fine_interior;
    logic signed [31:0]        r_boundary_value;
    logic                      restart;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fine_interior  <= 6'd63;
            r_boundary_value <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                grs7p_pkg::REG_FINE_INTERIOR:  r_fine_interior  <= i_cfg_data[5:0];
                grs7p_pkg::REG_BOUNDARY_VALUE: r_boundary_value <= i_cfg_data;
                default: ;
            endcase
        end
    end
    assign restart = i_cfg_we && i_cfg_idx == grs7p_pkg::REG_FINE_INTERIOR;

    // the pipe moves when the output register is empty or being taken
    logic                           en, vld;
    grs7p_pkg::t_ctl                ctl;
    logic signed [SAMPLE_WIDTH-1:0] val;
    assign en            = !vld || m_axis_tready;
    assign s_axis_tready = en;

    grs7p_core #(.MAX_INTERIOR(MAX_INTERIOR), .SAMPLE_WIDTH(SAMPLE_WIDTH)) u_core (
        .i_clk, .i_rst_n, .i_en(en), .i_in_vld(s_axis_tvalid),
        .i_sample(s_axis_tdata), .i_restart(restart),
        .i_fine_interior(r_fine_interior), .i_boundary_value(r_boundary_value),
        .o_vld(vld), .o_ctl(ctl), .o_value(val)
    );

    assign m_axis_tvalid = vld;
    assign m_axis_tdata  = OW'({val, ctl.cz, ctl.cy, ctl.cx});
    assign m_axis_tuser  = ctl.bnd;
    assign m_axis_tlast  = ctl.lst;
endmodule

### sv/grs7p_core.sv
// position tracking, three-plane store and pipelined stencil arithmetic
module grs7p_core #(
    parameter int MAX_INTERIOR = grs7p_pkg::MAX_INTERIOR_DEF,
    parameter int SAMPLE_WIDTH = grs7p_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_en,
    input  logic                           i_in_vld,
    input  logic signed [SAMPLE_WIDTH-1:0] i_sample,
    input  logic                           i_restart,
    input  logic [grs7p_pkg::N_W-1:0]      i_fine_interior,
    input  logic signed [31:0]             i_boundary_value,
    output logic                           o_vld,
    output grs7p_pkg::t_ctl                o_ctl,
    output logic signed [SAMPLE_WIDTH-1:0] o_value
);
    localparam int SIDE  = MAX_INTERIOR + 2;
    localparam int PW    = $clog2(SIDE + 1);
    localparam int PLANE = SIDE * SIDE;
    localparam int DEPTH = 3 * PLANE;
    localparam int AW    = $clog2(DEPTH);
    localparam int TOPN  = (MAX_INTERIOR - 1) | 1;
    localparam int QW    = SAMPLE_WIDTH - 3;
    localparam int SW    = SAMPLE_WIDTH + 4;
    localparam int CW    = grs7p_pkg::COORD_W;

    // reciprocal of three and the offsets that keep its operand non-negative
    localparam logic [SAMPLE_WIDTH-2:0] RECIP3 =
        (SAMPLE_WIDTH-1)'(((65'd1 << SAMPLE_WIDTH) + 65'd2) / 65'd3);
    localparam logic [SAMPLE_WIDTH-2:0] OFS3  = (SAMPLE_WIDTH-1)'(3) << (SAMPLE_WIDTH-3);
    localparam logic [SAMPLE_WIDTH-3:0] HALF3 = (SAMPLE_WIDTH-2)'(1) << (SAMPLE_WIDTH-3);

    // effective grid size
    logic [PW-1:0] n_eff, side;
    always_comb begin
        n_eff = PW'({2'b0, i_fine_interior} | 8'd1);
        if (n_eff < PW'(3)) n_eff = PW'(3);
        if (n_eff > PW'(TOPN)) n_eff = PW'(TOPN);
        side = n_eff + PW'(2);
    end

    // raster position and plane slot (z mod 3)
    logic [PW-1:0] r_x, r_y, r_z, n_x, n_y, n_z;
    logic [1:0]    r_zs, n_zs;
    logic [AW-1:0] r_rowb, n_rowb;
    always_comb begin
        n_x = r_x + PW'(1); n_y = r_y; n_z = r_z; n_zs = r_zs;
        if (n_x >= side) begin
            n_x = '0; n_y = r_y + PW'(1);
            if (n_y >= side) begin
                n_y = '0; n_z = r_z + PW'(1);
                n_zs = (r_zs == 2'd2) ? 2'd0 : r_zs + 2'd1;
                if (n_z >= side) begin
                    n_z = '0; n_zs = 2'd0;
                end
            end
        end
        n_rowb = AW'(n_zs) * AW'(PLANE) + AW'(n_y) * AW'(SIDE);
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_restart) begin
            r_x <= '0; r_y <= '0; r_z <= '0; r_zs <= '0; r_rowb <= '0;
        end else if (i_en && i_in_vld) begin
            r_x <= n_x; r_y <= n_y; r_z <= n_z; r_zs <= n_zs; r_rowb <= n_rowb;
        end
    end

    // stage 1: classify position and form six read addresses
    logic          bnd_hit, stc_hit;
    logic [PW-1:0] np1;
    always_comb begin
        np1 = n_eff + PW'(1);
        bnd_hit = ((r_x[0] | r_y[0] | r_z[0]) == 1'b0) &&
                  (r_x == '0 || r_y == '0 || r_z == '0 ||
                   r_x == np1 || r_y == np1 || r_z == np1);
        stc_hit = !r_x[0] && !r_y[0] && r_z[0] &&
                  r_x >= PW'(2) && r_x <= n_eff - PW'(1) &&
                  r_y >= PW'(2) && r_y <= n_eff - PW'(1) &&
                  r_z >= PW'(3) && r_z <= n_eff;
    end
    // centre plane is z-1, upper is z (the incoming one), lower is z-2
    logic [1:0]    zsc, zsl;
    logic [AW-1:0] cb, lb, wa;
    always_comb begin
        zsc = (r_zs == 2'd0) ? 2'd2 : r_zs - 2'd1;
        zsl = (zsc == 2'd0) ? 2'd2 : zsc - 2'd1;
        wa  = r_rowb + AW'(r_x);
        cb  = AW'(zsc) * AW'(PLANE) + AW'(r_y) * AW'(SIDE) + AW'(r_x);
        lb  = AW'(zsl) * AW'(PLANE) + AW'(r_y) * AW'(SIDE) + AW'(r_x);
    end

    logic                        r1_v;
    grs7p_pkg::t_ctl             r1_c;
    logic [AW-1:0]               r1_a [6];
    logic signed [SAMPLE_WIDTH-1:0] r1_up;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r1_v <= 1'b0;
        else if (i_en) r1_v <= i_in_vld && (bnd_hit || stc_hit);
        if (i_en) begin
            r1_c.bnd <= bnd_hit;
            r1_c.stc <= stc_hit && !bnd_hit;
            r1_c.lst <= r_x == np1 && r_y == np1 && r_z == np1;
            r1_c.cx  <= CW'(r_x >> 1);
            r1_c.cy  <= CW'(r_y >> 1);
            r1_c.cz  <= bnd_hit ? CW'(r_z >> 1) : CW'((r_z - PW'(1)) >> 1);
            r1_a[0]  <= cb;
            r1_a[1]  <= cb + AW'(1);
            r1_a[2]  <= cb - AW'(1);
            r1_a[3]  <= cb + AW'(SIDE);
            r1_a[4]  <= cb - AW'(SIDE);
            r1_a[5]  <= lb;
            r1_up    <= i_sample;
        end
    end

    // plane store: six banked copies, each one write and one read port
    logic signed [SAMPLE_WIDTH-1:0] mem0 [DEPTH], mem1 [DEPTH], mem2 [DEPTH];
    logic signed [SAMPLE_WIDTH-1:0] mem3 [DEPTH], mem4 [DEPTH], mem5 [DEPTH];
    logic signed [SAMPLE_WIDTH-1:0] r2_d [6];
    logic signed [SAMPLE_WIDTH-1:0] r2_up;
    logic                           r2_v;
    grs7p_pkg::t_ctl                r2_c;
    always_ff @(posedge i_clk) begin
        if (i_en && i_in_vld) begin
            mem0[wa] <= i_sample; mem1[wa] <= i_sample; mem2[wa] <= i_sample;
            mem3[wa] <= i_sample; mem4[wa] <= i_sample; mem5[wa] <= i_sample;
        end
        if (i_en) begin
            r2_d[0] <= mem0[r1_a[0]]; r2_d[1] <= mem1[r1_a[1]];
            r2_d[2] <= mem2[r1_a[2]]; r2_d[3] <= mem3[r1_a[3]];
            r2_d[4] <= mem4[r1_a[4]]; r2_d[5] <= mem5[r1_a[5]];
            r2_up   <= r1_up;
            r2_c    <= r1_c;
        end
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r2_v <= 1'b0;
        else if (i_en) r2_v <= r1_v;
    end

    // stage 3: each neighbour over twelve, quotient and small remainder
    // floor(v/12) as floor(floor(v/4)/3), the third by reciprocal multiply
    function automatic logic signed [QW-1:0] fdiv12(input logic signed [SAMPLE_WIDTH-1:0] v);
        logic signed [SAMPLE_WIDTH-3:0] u4;
        logic [SAMPLE_WIDTH-2:0]        w;
        logic [2*SAMPLE_WIDTH-3:0]      p;
        logic [SAMPLE_WIDTH-3:0]        t;
        u4 = (SAMPLE_WIDTH-2)'(v >>> 2);
        w  = {u4[SAMPLE_WIDTH-3], u4} + OFS3;
        p  = w * RECIP3;
        t  = p[2*SAMPLE_WIDTH-3:SAMPLE_WIDTH];
        return QW'(t - HALF3);
    endfunction
    logic signed [SAMPLE_WIDTH-1:0] nb [6];
    logic signed [QW-1:0]           q3 [6];
    logic [3:0]                     m3 [6];
    always_comb begin
        nb[0] = r2_d[1]; nb[1] = r2_d[2]; nb[2] = r2_d[3];
        nb[3] = r2_d[4]; nb[4] = r2_up;   nb[5] = r2_d[5];
        for (int i = 0; i < 6; i++) begin
            q3[i] = fdiv12(nb[i]);
            // remainder lies in 0..11, so the low four bits of nb - 12*q suffice
            m3[i] = nb[i][3:0] - {q3[i][1:0], 2'b00} - {q3[i][0], 3'b000};
        end
    end
    logic                           r3_v;
    grs7p_pkg::t_ctl                r3_c;
    logic signed [QW-1:0]           r3_q [6];
    logic [3:0]                     r3_m [6];
    logic signed [SAMPLE_WIDTH-1:0] r3_hc;
    logic                           r3_c0;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r3_v <= 1'b0;
        else if (i_en) r3_v <= r2_v;
        if (i_en) begin
            r3_c  <= r2_c;
            r3_hc <= r2_d[0] >>> 1;
            r3_c0 <= r2_d[0][0];
            for (int i = 0; i < 6; i++) begin
                r3_q[i] <= q3[i];
                r3_m[i] <= m3[i];
            end
        end
    end

    // stage 4: sum the quotients, finish with remainder over twelve by compare; boundary points take the boundary value
    logic signed [SW+2:0]           q4;
    logic [6:0]                     r4;
    logic [3:0]                     rq;
    logic signed [SAMPLE_WIDTH-1:0] res;
    always_comb begin
        q4 = (SW+3)'(r3_hc);
        r4 = r3_c0 ? 7'd12 : 7'd6;
        for (int i = 0; i < 6; i++) begin
            q4 = q4 + (SW+3)'(r3_q[i]);
            r4 = r4 + 7'(r3_m[i]);
        end
        rq = '0;
        for (int k = 1; k < 7; k++) begin
            if (r4 >= 7'(12 * k)) rq = rq + 4'd1;
        end
        res = SAMPLE_WIDTH'(q4 + (SW+3)'(rq));
        if (r3_c.bnd) res = SAMPLE_WIDTH'(i_boundary_value);
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) o_vld <= 1'b0;
        else if (i_en) o_vld <= r3_v;
        if (i_en) begin
            o_ctl <= r3_c; o_value <= res;
        end
    end
endmodule

### sv/grs7p_chk.sv
// port-level checker for the restriction block, bound to the top level
module grs7p_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       s_axis_tvalid,
    input logic       s_axis_tready,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic       m_axis_tuser,
    input logic       m_axis_tlast,
    input logic [5:0] cz
);
    a_last_bnd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tuser) else $error("last not boundary");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid) else $error("result dropped");
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready) else $error("stalled while empty");
    a_stencil_z: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |-> cz != 6'd0) else $error("stencil on face");
endmodule

bind grid_restrict_3d_7point_core grs7p_chk u_chk (
    .i_clk, .i_rst_n, .s_axis_tvalid, .s_axis_tready, .m_axis_tvalid,
    .m_axis_tready, .m_axis_tuser, .m_axis_tlast, .cz(m_axis_tdata[17:12])
);
